// File: hdl/vcb_pkg.sv
// ----------------------------------------------------------------------------
// vcb_pkg
// Types, memory map constants and helpers of the video chip bus interface.
// ----------------------------------------------------------------------------
package vcb_pkg;

	localparam int unsigned MemBytes = 20480;
	localparam int unsigned PalWords = 512;
	localparam int unsigned MemAw    = $clog2(MemBytes);
	localparam int unsigned PalAw    = $clog2(PalWords);

	localparam logic [14:0] AddrSprBase  = 15'h1000;
	localparam logic [14:0] AddrFgBase   = 15'h4000;
	localparam logic [14:0] FgIndexShift = 15'h3000;
	localparam logic [14:0] AddrPortA    = 15'h2010;
	localparam logic [14:0] AddrPortB    = 15'h2011;
	localparam logic [14:0] AddrPortC    = 15'h2012;
	localparam logic [14:0] AddrVidOff   = 15'h2012;
	localparam logic [14:0] AddrNmiOn    = 15'h2014;
	localparam logic [14:0] AddrIrqOn    = 15'h2015;
	localparam logic [4:0]  PalHiBits    = 5'b00110;   // 0x1800-0x1bff
	localparam logic [7:0]  Unmapped     = 8'hff;

	localparam logic ActRead  = 1'b0;
	localparam logic ActWrite = 1'b1;

	typedef struct packed {
		logic        action;
		logic [14:0] address;
		logic [7:0]  write_data;
		logic [7:0]  port_a_value;
		logic [7:0]  port_b_value;
		logic [7:0]  port_c_value;
	} vcb_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       color_valid;
		logic [8:0] color_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       video_off;
		logic       nmi_on;
		logic       irq_on;
	} vcb_rsp_t;

	function automatic logic [7:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	// sprite, palette and spare RAM, or foreground and background RAM
	function automatic logic is_ram(input logic [14:0] a);
		return a[14] || (a[14:12] == 3'b001);
	endfunction

	function automatic logic is_pal(input logic [14:0] a);
		return a[14:10] == PalHiBits;
	endfunction

	function automatic logic [MemAw-1:0] ram_index(input logic [14:0] a);
		logic [14:0] idx;
		idx = a - (a[14] ? FgIndexShift : AddrSprBase);
		return idx[MemAw-1:0];
	endfunction

endpackage

// File: hdl/vcb_if.sv
// ----------------------------------------------------------------------------
// vcb_if
// Valid/ready channels for bus requests and their responses.
// ----------------------------------------------------------------------------
interface vcb_req_if;
	logic               valid;
	logic               ready;
	vcb_pkg::vcb_req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vcb_rsp_if;
	logic               valid;
	logic               ready;
	vcb_pkg::vcb_rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/video_chip_bus_interface.sv
// ----------------------------------------------------------------------------
// video_chip_bus_interface
// Byte bus decoder onto video RAM, palette RAM, input ports and control bits.
// ----------------------------------------------------------------------------
// Usage:
//  req carries one bus transaction (read or write, 15-bit address, write
//  byte and the current values of input ports A, B and C). rsp returns one
//  transaction per request: read byte, palette update (index and expanded
//  RGB) and the three control bits as they stand after the access.
//  A request is captured with its video and palette RAM reads; in its
//  execute step the read data feeds the read-modify-write and the
//  response, which is registered in the output register. A new request
//  is taken only once the current one has committed.
//  The palette sits in its own 512 x 16 RAM so a byte write merges with
//  the other byte of its word and writes back in the same step.
//  After reset a clearing pass zeroes both RAMs, one entry a cycle;
//  req.ready stays low meanwhile. The control bits reset to 0.
//  A stalled response holds in the output register; one further request is
//  taken meanwhile and waits in its execute step until the register frees.
// ----------------------------------------------------------------------------
module video_chip_bus_interface (
	input  logic          clk,
	input  logic          arst_n,
	vcb_req_if.sink       req,
	vcb_rsp_if.source     rsp
);
	import vcb_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t            state_q;
	logic [MemAw-1:0]  clr_q;
	vcb_req_t          item_q;
	vcb_rsp_t          rsp_q;
	logic              rsp_valid_q;
	logic              video_off_q;
	logic              nmi_on_q;
	logic              irq_on_q;

	logic [7:0]        vram_mem [MemBytes];
	logic [15:0]       pal_mem  [PalWords];
	logic [7:0]        vram_rd_q;
	logic [15:0]       pal_rd_q;

	logic              accept;
	logic              commit;
	logic              it_ram;
	logic              it_pal;
	logic [15:0]       pal_word;
	vcb_rsp_t          rsp_d;

	logic              vram_we;
	logic [MemAw-1:0]  vram_waddr;
	logic [7:0]        vram_wdata;
	logic              pal_we;
	logic [PalAw-1:0]  pal_waddr;
	logic [15:0]       pal_wdata;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	assign it_ram = is_ram(item_q.address);
	assign it_pal = is_pal(item_q.address);

	// merge the written byte into its palette word
	assign pal_word = item_q.address[0] ? {item_q.write_data, pal_rd_q[7:0]}
	                                    : {pal_rd_q[15:8], item_q.write_data};

	always_comb begin
		rsp_d           = '0;
		rsp_d.video_off = video_off_q;
		rsp_d.nmi_on    = nmi_on_q;
		rsp_d.irq_on    = irq_on_q;
		unique case (item_q.action)
			ActRead: begin
				priority if (it_pal) begin
					rsp_d.read_data = item_q.address[0] ? pal_rd_q[15:8] : pal_rd_q[7:0];
				end else if (it_ram) begin
					rsp_d.read_data = vram_rd_q;
				end else if (item_q.address == AddrPortA) begin
					rsp_d.read_data = item_q.port_a_value;
				end else if (item_q.address == AddrPortB) begin
					rsp_d.read_data = item_q.port_b_value;
				end else if (item_q.address == AddrPortC) begin
					rsp_d.read_data = item_q.port_c_value;
				end else begin
					rsp_d.read_data = Unmapped;
				end
			end
			ActWrite: begin
				priority if (it_pal) begin
					rsp_d.color_valid = 1'b1;
					rsp_d.color_index = item_q.address[PalAw:1];
					rsp_d.red         = expand5(pal_word[4:0]);
					rsp_d.green       = expand5(pal_word[9:5]);
					rsp_d.blue        = expand5(pal_word[14:10]);
				end else if (it_ram) begin
					rsp_d.read_data = '0;
				end else if (item_q.address == AddrVidOff) begin
					rsp_d.video_off = item_q.write_data[0];
				end else if (item_q.address == AddrNmiOn) begin
					rsp_d.nmi_on = item_q.write_data[0];
				end else if (item_q.address == AddrIrqOn) begin
					rsp_d.irq_on = item_q.write_data[0];
				end else begin
					rsp_d.read_data = '0;
				end
			end
			default: rsp_d.read_data = '0;
		endcase
	end

	// write port: clearing pass, else write-back at commit
	always_comb begin
		if (state_q == ST_CLEAR) begin
			vram_we    = 1'b1;
			vram_waddr = clr_q;
			vram_wdata = '0;
			pal_we     = (clr_q[MemAw-1:PalAw] == '0);
			pal_waddr  = clr_q[PalAw-1:0];
			pal_wdata  = '0;
		end else begin
			vram_we    = commit && (item_q.action == ActWrite) && it_ram && !it_pal;
			vram_waddr = ram_index(item_q.address);
			vram_wdata = item_q.write_data;
			pal_we     = commit && (item_q.action == ActWrite) && it_pal;
			pal_waddr  = item_q.address[PalAw:1];
			pal_wdata  = pal_word;
		end
	end

	always_ff @(posedge clk) begin
		if (vram_we) begin
			vram_mem[vram_waddr] <= vram_wdata;
		end
		if (accept) begin
			vram_rd_q <= vram_mem[ram_index(req.data.address)];
		end
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_waddr] <= pal_wdata;
		end
		if (accept) begin
			pal_rd_q <= pal_mem[req.data.address[PalAw:1]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req.data;
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			video_off_q <= 1'b0;
			nmi_on_q    <= 1'b0;
			irq_on_q    <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MemAw'(MemBytes - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// hold until the output register frees
					if (commit) begin
						state_q     <= ST_IDLE;
						video_off_q <= rsp_d.video_off;
						nmi_on_q    <= rsp_d.nmi_on;
						irq_on_q    <= rsp_d.irq_on;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// File: hdl/vcb_checker.sv
// ----------------------------------------------------------------------------
// vcb_checker
// Port-level checks on the video chip bus interface, bound to the top level.
// ----------------------------------------------------------------------------
module vcb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input vcb_pkg::vcb_rsp_t rsp_data
);
	import vcb_pkg::*;

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// no request is taken back-to-back with the one before
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken in back-to-back cycles");

	// a palette update carries zero read data, as from a write
	a_pal_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.color_valid |-> rsp_data.read_data == 8'h00)
		else $error("palette update carries read data");

	// no palette update: colour fields are zero
	a_no_pal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.color_valid |->
			rsp_data.color_index == '0 && rsp_data.red == '0 &&
			rsp_data.green == '0 && rsp_data.blue == '0)
		else $error("colour fields set without a palette update");

	// channels expand by bit replication
	a_expand: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.red[2:0] == rsp_data.red[7:5] &&
			rsp_data.green[2:0] == rsp_data.green[7:5] &&
			rsp_data.blue[2:0] == rsp_data.blue[7:5])
		else $error("colour channel not replicated");

endmodule

bind video_chip_bus_interface vcb_checker u_vcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
